// ===== design/istk_pkg.sv =====
package istk_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_DUMP = 2'd1,
    OP_ADD  = 2'd2,
    OP_POP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== design/istk_ram.sv =====
module istk_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/istk_ctrl.sv =====
module istk_ctrl import istk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_item_value,
  output logic [1:0]               out_status,
  output logic                     out_last,
  output ram_req_t                 ram_req,
  input  logic [DATA_W-1:0]        ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADD_RD2,
    S_ADD_WR,
    S_DUMP
  } state_t;

  state_t            state_r, state_nxt;
  opcode_t           op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [DATA_W-1:0] sum;

  assign slot_free = !out_valid_r || out_ready;
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cnt_m2    = cnt_r - CNT_W'(2);
  assign sum       = ram_rdata + top_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_req.we     = 1'b0;
    ram_req.re     = 1'b0;
    ram_req.addr   = cnt_r[ADDR_W-1:0];
    ram_req.wdata  = val_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = opcode_t'(in_opcode);
          val_nxt   = in_push_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_PUSH: begin
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                ram_req.we     = 1'b1;
                ram_req.addr   = cnt_r[ADDR_W-1:0];
                cnt_nxt        = cnt_r + CNT_W'(1);
                out_status_nxt = ST_OK;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_POP: begin
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_last_nxt  = 1'b1;
              if (cnt_r == '0) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                cnt_nxt        = cnt_m1;
                out_status_nxt = ST_OK;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_DUMP: begin
            if (cnt_r == '0) begin
              if (slot_free) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = ST_EMPTY;
                out_last_nxt   = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              ram_req.re   = 1'b1;
              ram_req.addr = cnt_m1[ADDR_W-1:0];
              ptr_nxt      = cnt_m1[ADDR_W-1:0];
              state_nxt    = S_DUMP;
            end
          end
          OP_ADD: begin
            if (cnt_r < CNT_W'(2)) begin
              if (slot_free) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = ST_UNDERFLOW;
                out_last_nxt   = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              ram_req.re   = 1'b1;
              ram_req.addr = cnt_m1[ADDR_W-1:0];
              state_nxt    = S_ADD_RD2;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADD_RD2: begin
        top_nxt      = ram_rdata;
        ram_req.re   = 1'b1;
        ram_req.addr = cnt_m2[ADDR_W-1:0];
        state_nxt    = S_ADD_WR;
      end
      S_ADD_WR: begin
        // second operand sits in the RAM read register until the slot frees
        if (slot_free) begin
          ram_req.we     = 1'b1;
          ram_req.addr   = cnt_m2[ADDR_W-1:0];
          ram_req.wdata  = sum;
          cnt_nxt        = cnt_m1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = sum;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = ram_rdata;
          out_status_nxt = ST_OK;
          out_last_nxt   = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt      = ptr_r - ADDR_W'(1);
            ram_req.re   = 1'b1;
            ram_req.addr = ptr_r - ADDR_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    top_r        <= top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_item_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

// ===== design/integer_stack_with_add.sv =====
// channel | ports                                    | direction
// in      | in_valid in_ready in_opcode in_push_value  | into block
// out     | out_valid out_ready out_item_value          | out of block
//         | out_status out_last                         |
// One word in at a time; add does two reads and one write-back on the single-port
// stack RAM unless it underflows, and dump returns one result word per entry (a
// single empty word when the stack is empty). A stalled result holds the operation.
// The RAM read register holds its data while the result register is stalled.
// Synchronous active-low reset empties the stack; RAM contents are not cleared.
// A finished result waits in the output register; the next word can be taken meanwhile.
module integer_stack_with_add import istk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_item_value,
  output logic [1:0]               out_status,
  output logic                     out_last
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  istk_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  istk_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/istk_chk.sv =====
module istk_chk import istk_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_item_value,
  input logic [1:0]               out_status,
  input logic                     out_last
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_value)
      && $stable(out_status) && $stable(out_last))
    else $error("result word changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // error and empty results always close their item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_item_value == '0)
    else $error("error result with nonzero value");

  // a new word is taken only after the previous one has begun to settle
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("two words accepted in consecutive cycles");

endmodule

bind integer_stack_with_add istk_chk u_istk_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_item_value (out_item_value),
  .out_status     (out_status),
  .out_last       (out_last)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import istk_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = STACK_DEPTH + 16;
  localparam int PHASE_WORDS = 50;
  localparam int N_DIR       = 21;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic              last;
  } stack_result_t;

  typedef struct packed {
    opcode_t           op;
    logic [DATA_W-1:0] operand;
    logic              typed_in;
    logic [DATA_W-1:0] want_value;
    status_t           want_status;
  } word_t;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_opcode     = OP_PUSH;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic signed [DATA_W-1:0] out_item_value;
  logic [1:0]               out_status;
  logic                     out_last;

  // shadow copy of the stack, updated when a word is accepted
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_cnt = 0;
  stack_result_t     result_q [$];
  stack_result_t     want_res;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int idle_cycles   = 0;
  int err_cnt       = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int op_cnt [4]    = '{0, 0, 0, 0};
  int overflow_cnt  = 0;
  int underflow_cnt = 0;
  int empty_dump_cnt = 0;
  int max_depth     = 0;

  // directed words; typed_in rows carry their single expected result
  word_t dir_words [N_DIR] = '{
    '{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_ADD,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_DUMP, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_ADD,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_PUSH, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_ADD,  32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
    '{OP_PUSH, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_ADD,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH, 32'h5555_5555, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_DUMP, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_ADD,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_POP,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_DUMP, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{OP_PUSH, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_DUMP, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
  };

  integer_stack_with_add i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item_value(out_item_value),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic stack_result_t make_result(input logic [DATA_W-1:0] v,
                                                input status_t s, input logic l);
    make_result = '{value: v, status: s, last: l};
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // applies one accepted word to the shadow stack, queues the words it yields
  task automatic stack_apply(input opcode_t op, input logic [DATA_W-1:0] operand);
    logic [DATA_W-1:0] sum;
    op_cnt[op]++;
    case (op)
      OP_PUSH: begin
        if (shadow_cnt >= STACK_DEPTH) begin
          overflow_cnt++;
          result_q.push_back(make_result('0, ST_OVERFLOW, 1'b1));
        end else begin
          shadow_stack[shadow_cnt] = operand;
          shadow_cnt++;
          result_q.push_back(make_result('0, ST_OK, 1'b1));
        end
      end
      OP_DUMP: begin
        if (shadow_cnt == 0) begin
          empty_dump_cnt++;
          result_q.push_back(make_result('0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = int'(shadow_cnt) - 1; i >= 0; i--)
            result_q.push_back(make_result(shadow_stack[i], ST_OK, i == 0));
        end
      end
      OP_ADD: begin
        if (shadow_cnt < 2) begin
          underflow_cnt++;
          result_q.push_back(make_result('0, ST_UNDERFLOW, 1'b1));
        end else begin
          sum = shadow_stack[shadow_cnt-1] + shadow_stack[shadow_cnt-2];
          shadow_cnt--;
          shadow_stack[shadow_cnt-1] = sum;
          result_q.push_back(make_result(sum, ST_OK, 1'b1));
        end
      end
      default: begin
        if (shadow_cnt == 0) begin
          underflow_cnt++;
          result_q.push_back(make_result('0, ST_UNDERFLOW, 1'b1));
        end else begin
          shadow_cnt--;
          result_q.push_back(make_result('0, ST_OK, 1'b1));
        end
      end
    endcase
    if (int'(shadow_cnt) > max_depth) max_depth = int'(shadow_cnt);
  endtask

  // drives one word, waits for it to be taken, then maybe idles
  task automatic send_word(input word_t w);
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= w.op;
    in_push_value <= w.operand;
    do @(posedge clk); while (!in_ready);
    stack_apply(w.op, w.operand);
    if (w.typed_in) begin
      void'(result_q.pop_back());
      result_q.push_back(make_result(w.want_value, w.want_status, 1'b1));
    end
    words_sent++;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 7))
      0:       random_operand = 32'h0000_0000;
      1:       random_operand = 32'h7FFF_FFFF;
      2:       random_operand = 32'h8000_0000;
      3:       random_operand = 32'hFFFF_FFFF;
      default: random_operand = $urandom;
    endcase
  endfunction

  function automatic word_t plain_word(input opcode_t op);
    plain_word = '{op: op, operand: random_operand(), typed_in: 1'b0,
                   want_value: '0, want_status: ST_OK};
  endfunction

  function automatic opcode_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      pick_op = OP_PUSH;
    else if (r < 70) pick_op = OP_ADD;
    else if (r < 85) pick_op = OP_POP;
    else             pick_op = OP_DUMP;
  endfunction

  // push to full, bounce off the top, dump everything, then fold it back down
  task automatic fill_and_drain();
    while (shadow_cnt < STACK_DEPTH) send_word(plain_word(OP_PUSH));
    repeat ($urandom_range(1, 2)) send_word(plain_word(OP_PUSH));
    send_word(plain_word(OP_DUMP));
    while (shadow_cnt > 3) send_word(plain_word($urandom_range(0, 1) ? OP_ADD : OP_POP));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        flag_error($sformatf("unexpected word: value %h status %0d last %0b",
                             out_item_value, out_status, out_last));
      end else begin
        want_res = result_q.pop_front();
        results_seen++;
        if (out_item_value !== want_res.value)
          flag_error($sformatf("item_value: got %h, want %h",
                               out_item_value, want_res.value));
        if (out_status !== want_res.status)
          flag_error($sformatf("status: got %0d, want %s",
                               out_status, want_res.status.name()));
        if (out_last !== want_res.last)
          flag_error($sformatf("last: got %0b, want %0b", out_last, want_res.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, result_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    int phase_start;
    idle_plan  = '{0, 50, 0, 18};
    stall_plan = '{0, 0, 50, 18};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) send_word(dir_words[i]);

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = idle_plan[ph];
      out_stall_pct = stall_plan[ph];
      if (ph == 2) fill_and_drain();
      phase_start   = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) send_word(plain_word(pick_op()));
    end

    if (in_valid) in_valid <= 1'b0;
    out_stall_pct = 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d words (push %0d, dump %0d, add %0d, pop %0d), checked %0d results",
             words_sent, op_cnt[OP_PUSH], op_cnt[OP_DUMP], op_cnt[OP_ADD], op_cnt[OP_POP],
             results_seen);
    $display("deepest stack %0d, %0d overflows, %0d underflows, %0d empty dumps",
             max_depth, overflow_cnt, underflow_cnt, empty_dump_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/istk_pkg.sv
design/istk_ram.sv
design/istk_ctrl.sv
design/integer_stack_with_add.sv
design/istk_chk.sv
test/tb_top.sv
